/* hdl/sbfr_pkg.sv */
// ----------------------------------------------------------------------------
// sbfr_pkg
// shared constants and types for the byte-stuffed frame receiver
// ----------------------------------------------------------------------------
package sbfr_pkg;

   localparam int LINE_BYTES_DEF    = 64;
   localparam int DISPLAY_LINES_DEF = 16;
   localparam int SCRATCH_BYTES_DEF = 80;

   localparam logic [7:0] MARK_BYTE = 8'h01;
   localparam logic [7:0] ESC_BYTE  = 8'h1B;
   localparam logic [7:0] ESC_MASK  = 8'h7F;

   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   localparam logic EV_STORE = 1'b0;
   localparam logic EV_DONE  = 1'b1;

   localparam int ADDR_W = 10;

   typedef struct packed {
      logic              event_res;
      logic [7:0]        frame_type;
      logic              to_display;
      logic [ADDR_W-1:0] store_address;
      logic [7:0]        store_data;
   } rsp_type;

endpackage

/* hdl/sbfr_core.sv */
// ----------------------------------------------------------------------------
// sbfr_core
// per-beat deframing step: next state and optional result from one byte
// ----------------------------------------------------------------------------
module sbfr_core #(
   parameter int LINE_BYTES    = 64,
   parameter int DISPLAY_LINES = 16,
   parameter int SCRATCH_BYTES = 80,
   parameter int OFF_W         = 9
) (
   input  logic [7:0]       rx_byte,
   input  logic [1:0]       phase,
   input  logic             esc,
   input  logic [7:0]       cur_type,
   input  logic [OFF_W-1:0] offset,
   output logic [1:0]       phase_in,
   output logic             esc_in,
   output logic [7:0]       type_in,
   output logic [OFF_W-1:0] offset_in,
   output logic             res_vld,
   output sbfr_pkg::rsp_type res
);
   import sbfr_pkg::*;

   localparam int PROD_W = 8 + $clog2(LINE_BYTES + 1) + 1;

   logic             is_disp;
   logic [OFF_W-1:0] region;
   logic [7:0]       unesc;
   logic [PROD_W-1:0] disp_addr;

   assign is_disp   = {1'b0, cur_type} < 9'(DISPLAY_LINES);
   assign region    = is_disp ? OFF_W'(LINE_BYTES) : OFF_W'(SCRATCH_BYTES);
   assign unesc     = esc ? (rx_byte & ESC_MASK) : rx_byte;
   assign disp_addr = PROD_W'(cur_type) * PROD_W'(LINE_BYTES) + PROD_W'(offset);

   always_comb begin
      phase_in  = phase;
      esc_in    = esc;
      type_in   = cur_type;
      offset_in = offset;
      res_vld   = 1'b0;
      res.event_res     = EV_STORE;
      res.frame_type    = cur_type;
      res.to_display    = is_disp;
      res.store_address = '0;
      res.store_data    = '0;
      unique case (phase)
         PH_TYPE: begin
            if (rx_byte == ESC_BYTE) begin
               esc_in = 1'b1;
            end else if (rx_byte != MARK_BYTE) begin
               type_in   = unesc;
               esc_in    = 1'b0;
               offset_in = '0;
               phase_in  = PH_DATA;
            end
         end
         PH_DATA: begin
            if (rx_byte == MARK_BYTE) begin
               phase_in      = PH_WAIT;
               res_vld       = 1'b1;
               res.event_res = EV_DONE;
            end else if (rx_byte == ESC_BYTE) begin
               esc_in = 1'b1;
            end else begin
               esc_in = 1'b0;
               if (offset < region) begin
                  offset_in         = offset + OFF_W'(1);
                  res_vld           = 1'b1;
                  res.store_data    = unesc;
                  res.store_address = is_disp ? disp_addr[ADDR_W-1:0]
                                              : ADDR_W'(offset);
               end
            end
         end
         default: begin
            // unused phase code behaves as waiting for start
            phase_in = (rx_byte == MARK_BYTE) ? PH_TYPE : PH_WAIT;
         end
      endcase
   end

endmodule

/* hdl/stx_byte_stuffed_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// stx_byte_stuffed_frame_receiver_top
// result path: an accepted byte beat is held in the input register, then its result in the result register
// throughput: one byte beat per cycle while results are taken, set by the input and result registers
// reset: synchronous, waits for start with no escape pending and empty stages
// ----------------------------------------------------------------------------
module stx_byte_stuffed_frame_receiver_top #(
   parameter int LINE_BYTES    = sbfr_pkg::LINE_BYTES_DEF,
   parameter int DISPLAY_LINES = sbfr_pkg::DISPLAY_LINES_DEF,
   parameter int SCRATCH_BYTES = sbfr_pkg::SCRATCH_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_event_res,
   output logic [7:0]                  rsp_frame_type,
   output logic                        rsp_to_display,
   output logic [sbfr_pkg::ADDR_W-1:0] rsp_store_address,
   output logic [7:0]                  rsp_store_data
);
   import sbfr_pkg::*;

   localparam int MAX_REGION = (LINE_BYTES > SCRATCH_BYTES) ? LINE_BYTES : SCRATCH_BYTES;
   localparam int OFF_W      = $clog2(MAX_REGION + 1);

   logic             in_vld_ff;
   logic [7:0]       in_byte_ff;
   logic [1:0]       phase_ff, phase_in;
   logic             esc_ff, esc_in;
   logic [7:0]       type_ff, type_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic             rsp_vld_ff;
   rsp_type          rsp_ff;
   logic             res_vld;
   rsp_type          res;
   logic             advance;

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   sbfr_core #(
      .LINE_BYTES    (LINE_BYTES),
      .DISPLAY_LINES (DISPLAY_LINES),
      .SCRATCH_BYTES (SCRATCH_BYTES),
      .OFF_W         (OFF_W)
   ) u_core (
      .rx_byte   (in_byte_ff),
      .phase     (phase_ff),
      .esc       (esc_ff),
      .cur_type  (type_ff),
      .offset    (off_ff),
      .phase_in  (phase_in),
      .esc_in    (esc_in),
      .type_in   (type_in),
      .offset_in (off_in),
      .res_vld   (res_vld),
      .res       (res)
   );

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         esc_ff   <= 1'b0;
         type_ff  <= '0;
         off_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         type_ff  <= type_in;
         off_ff   <= off_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= res_vld;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance && res_vld) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_event_res     = rsp_ff.event_res;
   assign rsp_frame_type    = rsp_ff.frame_type;
   assign rsp_to_display    = rsp_ff.to_display;
   assign rsp_store_address = rsp_ff.store_address;
   assign rsp_store_data    = rsp_ff.store_data;

endmodule
